>>> src/txst_pkg.sv
// ----------------------------------------------------------------------------
// txst_pkg: shared types and constants of the tx status slot tracker
// Command, result and status codes, beat payload structs and queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

package txst_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_SEND   = 2'd0,
    CMD_STATUS = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_SEND   = 2'd0,
    OP_STATUS = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_DEFERRED  = 3'd1,
    KIND_FAILED    = 3'd2,
    KIND_MATCHED   = 3'd3,
    KIND_UNMATCHED = 3'd4,
    KIND_TIMEOUT   = 3'd5
  } kind_e;

  // Reported transmit status
  typedef enum logic [1:0] {
    TXS_OK    = 2'd0,
    TXS_ERR   = 2'd1,
    TXS_FATAL = 2'd2,
    TXS_NOACK = 2'd3
  } txs_e;

  // Radio handoff result codes
  localparam logic [1:0] RADIO_OK  = 2'd0;
  localparam logic [1:0] RADIO_ERR = 2'd1;

  // Back end sequencer states
  typedef enum logic {
    B_IDLE = 1'b0,
    B_TICK = 1'b1
  } back_state_e;

  localparam logic [7:0]  TIMEOUT_TRIES    = 8'd6;
  localparam logic [15:0] WAIT_TICKS_RESET = 16'd1311;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] seq;
    logic       is_mgmt;
    logic       header_ok;
    logic [1:0] radio_result;
    logic       success;
    logic [7:0] tx_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [1:0] tx_status;
    logic [7:0] report_seq;
    logic [3:0] slot_index;
    logic [7:0] attempts;
    logic       last;
  } out_item_t;

  typedef struct packed {
    op_e      op;
    in_item_t item;
  } q_entry_t;

endpackage

`default_nettype wire

>>> src/txst_front.sv
// ----------------------------------------------------------------------------
// txst_front: input side of the tx status slot tracker
// Accepts input beats, classifies the command, drops unused codes and
// queues the rest in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module txst_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire txst_pkg::in_item_t in_item_i,
  output logic                    q_valid_o,
  output txst_pkg::q_entry_t      q_entry_o,
  input  wire logic               q_pop_i
);
  import txst_pkg::*;

  logic [1:0] count_q, count_d;
  logic       wr_ptr_q, rd_ptr_q;
  q_entry_t   mem_q [2];
  q_entry_t   entry;
  logic       keep;
  logic       push, pop;

  // Classify the command; unused codes are dropped
  always_comb begin
    keep       = 1'b1;
    entry.op   = OP_SEND;
    entry.item = in_item_i;
    case (in_item_i.command)
      CMD_SEND:   entry.op = OP_SEND;
      CMD_STATUS: entry.op = OP_STATUS;
      CMD_TICK:   entry.op = OP_TICK;
      default:    keep = 1'b0;
    endcase
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o && keep;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Hold queued entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

>>> src/txst_back.sv
// ----------------------------------------------------------------------------
// txst_back: slot engine of the tx status slot tracker
// Executes queued sends, status reports and ticks against the slot state
// and drives results through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module txst_back #(
  parameter int unsigned SLOT_COUNT = 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [15:0]         wait_ticks_i,
  input  wire logic                q_valid_i,
  input  wire txst_pkg::q_entry_t  q_entry_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output txst_pkg::out_item_t      out_item_o
);
  import txst_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  back_state_e             state_q, state_d;
  logic [IW-1:0]           idx_q, idx_d;
  logic [SLOT_COUNT-1:0]   busy_q, busy_d;
  logic [7:0]              seq_q [SLOT_COUNT];
  logic [15:0]             cd_q  [SLOT_COUNT];
  logic                    out_valid_q;
  out_item_t               out_q;

  logic                    can_emit, emit;
  out_item_t               res;
  logic                    wr_en, dec_en;
  logic [IW-1:0]           wr_slot;
  logic                    free_found, match_found;
  logic [IW-1:0]           free_sel, match_sel;
  logic [SLOT_COUNT-1:0]   exp_vec;
  logic                    later_exp;

  // Search free management slot and matching slot, lowest index wins
  always_comb begin
    free_found  = 1'b0;
    free_sel    = '0;
    match_found = 1'b0;
    match_sel   = '0;
    for (int j = SLOT_COUNT - 1; j >= 1; j--) begin
      if (!busy_q[j]) begin
        free_found = 1'b1;
        free_sel   = IW'(j);
      end
    end
    for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
      if (busy_q[j] && (seq_q[j] == q_entry_i.item.seq)) begin
        match_found = 1'b1;
        match_sel   = IW'(j);
      end
    end
  end

  // Flag slots that expire on this tick and any beyond the walk position
  always_comb begin
    later_exp = 1'b0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      exp_vec[j] = busy_q[j] && (cd_q[j][15:1] == 15'd0);
      if ((j > int'(idx_q)) && exp_vec[j]) begin
        later_exp = 1'b1;
      end
    end
  end

  assign can_emit = !out_valid_q || out_ready_i;

  // Sequence operations and build results
  always_comb begin
    logic [IW-1:0] tgt;
    logic          advance;
    tgt      = '0;
    advance  = 1'b0;
    state_d  = state_q;
    idx_d    = idx_q;
    busy_d   = busy_q;
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    wr_en    = 1'b0;
    wr_slot  = '0;
    dec_en   = 1'b0;
    res      = '0;
    res.report_seq = q_entry_i.item.seq;
    res.last       = 1'b1;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.op)
            OP_SEND: begin
              if (can_emit) begin
                q_pop_o = 1'b1;
                emit    = 1'b1;
                if (!q_entry_i.item.header_ok ||
                    (q_entry_i.item.is_mgmt && !free_found)) begin
                  res.result_kind = KIND_FAILED;
                  res.tx_status   = TXS_FATAL;
                end else if (!q_entry_i.item.is_mgmt && busy_q[0]) begin
                  res.result_kind = KIND_DEFERRED;
                  res.tx_status   = TXS_OK;
                end else begin
                  tgt            = q_entry_i.item.is_mgmt ? free_sel : '0;
                  res.slot_index = 4'(tgt);
                  if (q_entry_i.item.radio_result == RADIO_OK) begin
                    res.result_kind = KIND_ACCEPTED;
                    res.tx_status   = TXS_OK;
                    busy_d[tgt]     = 1'b1;
                    wr_en           = 1'b1;
                    wr_slot         = tgt;
                  end else begin
                    // radio failure leaves the target slot free
                    res.result_kind = KIND_FAILED;
                    res.tx_status   = (q_entry_i.item.radio_result == RADIO_ERR) ?
                                      TXS_ERR : TXS_FATAL;
                    busy_d[tgt]     = 1'b0;
                  end
                end
              end
            end
            OP_STATUS: begin
              if (can_emit) begin
                q_pop_o = 1'b1;
                emit    = 1'b1;
                if (match_found) begin
                  res.result_kind   = KIND_MATCHED;
                  res.tx_status     = q_entry_i.item.success ? TXS_OK : TXS_ERR;
                  res.slot_index    = 4'(match_sel);
                  res.attempts      = q_entry_i.item.tx_count;
                  busy_d[match_sel] = 1'b0;
                end else begin
                  res.result_kind = KIND_UNMATCHED;
                  res.tx_status   = TXS_FATAL;
                end
              end
            end
            OP_TICK: begin
              q_pop_o = 1'b1;
              idx_d   = '0;
              state_d = B_TICK;
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      B_TICK: begin
        // walk one slot per cycle; stall only on an expiry with output full
        if (exp_vec[idx_q]) begin
          if (can_emit) begin
            emit            = 1'b1;
            res.result_kind = KIND_TIMEOUT;
            res.tx_status   = TXS_NOACK;
            res.report_seq  = seq_q[idx_q];
            res.slot_index  = 4'(idx_q);
            res.attempts    = TIMEOUT_TRIES;
            res.last        = !later_exp;
            busy_d[idx_q]   = 1'b0;
            advance         = 1'b1;
          end
        end else begin
          dec_en  = busy_q[idx_q];
          advance = 1'b1;
        end
        if (advance) begin
          if (idx_q == LAST_IDX) begin
            state_d = B_IDLE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      idx_q       <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      busy_q  <= busy_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot payload and output beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      seq_q[wr_slot] <= q_entry_i.item.seq;
      cd_q[wr_slot]  <= wait_ticks_i;
    end
    if (dec_en) begin
      cd_q[idx_q] <= cd_q[idx_q] - 16'd1;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Queue is never popped while walking a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_TICK) |-> !q_pop_o)
    else $error("queue popped during tick walk");

  // Timeout results come only from the tick walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (res.result_kind == KIND_TIMEOUT)) |-> (state_q == B_TICK))
    else $error("timeout outside tick walk");

  // Accepting into the data slot requires it to be free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (res.result_kind == KIND_ACCEPTED) && (res.slot_index == 4'd0))
      |-> !busy_q[0])
    else $error("data slot accepted while busy");

  // A match frees exactly one slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (res.result_kind == KIND_MATCHED))
      |=> ($countones(busy_q) + 1 == $past($countones(busy_q))))
    else $error("match did not free one slot");

  // A new beat is never loaded while the held one is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit)
    else $error("output beat overwritten");

endmodule

`default_nettype wire

>>> src/tx_status_slot_tracker.sv
// ----------------------------------------------------------------------------
// tx_status_slot_tracker: one data slot and MGMT_SLOTS management slots.
// A send or status result is registered in the front queue and then in the back
// end output register before its output beat is presented.
// Throughput: one send or status per cycle while the output is not stalled; a
// tick holds the back end while it is dequeued and while it walks each slot in
// turn, longer while a timeout beat waits.
// Reset: all slots free, wait_ticks 1311, queue and output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tx_status_slot_tracker #(
  parameter int unsigned MGMT_SLOTS = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire txst_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output txst_pkg::out_item_t       out_item_o
);
  import txst_pkg::*;

  localparam int unsigned SLOT_COUNT = 1 + MGMT_SLOTS;

  logic [15:0] wait_ticks_q;
  logic        q_valid;
  q_entry_t    q_entry;
  logic        q_pop;

  // Hold the status wait register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_ticks_q <= WAIT_TICKS_RESET;
    end else if (cfg_we_i) begin
      wait_ticks_q <= cfg_wdata_i;
    end
  end

  txst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  txst_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wait_ticks_i (wait_ticks_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tx status slot tracker
// Drives send requests, status reports and timer ticks over valid/ready with
// random idling on both sides, tracks the slot state in a local scoreboard
// and checks every result beat field by field, in order. A directed table
// runs first, then random phases under several wait_ticks settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import txst_pkg::*;

  localparam int unsigned MGMT_SLOTS    = 4;
  localparam int unsigned SLOTS         = 1 + MGMT_SLOTS;
  localparam int unsigned ITEM_W        = $bits(in_item_t);
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AFTER    = 60;
  localparam int unsigned PHASE_ITEMS   = 56;
  localparam int unsigned MAX_PRINTS    = 50;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] RADIO_FATAL = 2'd2;
  localparam logic [1:0] RADIO_BAD   = 2'd3;

  localparam logic [15:0] PHASE_WAIT [6] = '{16'd3, 16'hffff, 16'd2,
                                             WAIT_TICKS_RESET, 16'd1, 16'd9};

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // Scoreboard copy of the slot state
  bit          trk_busy [SLOTS];
  logic [7:0]  trk_seq  [SLOTS];
  logic [15:0] trk_count[SLOTS];
  logic [15:0] tb_wait_ticks;

  out_item_t   fresh_reports[$];
  out_item_t   due_reports[$];
  stim_row_t   plan[$];

  int unsigned fail_count;
  int unsigned reports_seen;
  int unsigned cycle_count;
  bit          calm;

  tx_status_slot_tracker #(
    .MGMT_SLOTS(MGMT_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // Run the clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic out_item_t slot_report(kind_e kind, txs_e st, logic [7:0] sq,
                                            logic [3:0] slot, logic [7:0] tries);
    out_item_t r;
    r.result_kind = kind;
    r.tx_status   = st;
    r.report_seq  = sq;
    r.slot_index  = slot;
    r.attempts    = tries;
    r.last        = 1'b1;
    return r;
  endfunction

  // Beat builders: fields the command ignores stay random
  function automatic in_item_t send_of(logic [7:0] sq, logic mgmt, logic hdr,
                                       logic [1:0] radio);
    in_item_t b;
    b              = in_item_t'(ITEM_W'($urandom));
    b.command      = CMD_SEND;
    b.seq          = sq;
    b.is_mgmt      = mgmt;
    b.header_ok    = hdr;
    b.radio_result = radio;
    return b;
  endfunction

  function automatic in_item_t status_of(logic [7:0] sq, logic ok, logic [7:0] tries);
    in_item_t b;
    b          = in_item_t'(ITEM_W'($urandom));
    b.command  = CMD_STATUS;
    b.seq      = sq;
    b.success  = ok;
    b.tx_count = tries;
    return b;
  endfunction

  function automatic in_item_t tick_of(logic [1:0] cmd);
    in_item_t b;
    b         = in_item_t'(ITEM_W'($urandom));
    b.command = cmd;
    return b;
  endfunction

  // Advance the slot state by one beat and collect the reports it causes
  function automatic void advance_slots(in_item_t b);
    int        slot;
    bit        hit;
    int        i;
    out_item_t r;
    fresh_reports.delete();
    case (b.command)
      CMD_SEND: begin
        slot = -1;
        if (!b.header_ok) begin
          fresh_reports.push_back(slot_report(KIND_FAILED, TXS_FATAL, b.seq, 4'd0, 8'd0));
        end else if (b.is_mgmt) begin
          for (i = 1; i < SLOTS; i++) begin
            if (!trk_busy[i] && slot < 0) slot = i;
          end
          if (slot < 0) begin
            fresh_reports.push_back(slot_report(KIND_FAILED, TXS_FATAL, b.seq, 4'd0, 8'd0));
          end
        end else if (trk_busy[0]) begin
          fresh_reports.push_back(slot_report(KIND_DEFERRED, TXS_OK, b.seq, 4'd0, 8'd0));
        end else begin
          slot = 0;
        end
        if (slot >= 0) begin
          if (b.radio_result == RADIO_OK) begin
            trk_busy[slot]  = 1'b1;
            trk_seq[slot]   = b.seq;
            trk_count[slot] = tb_wait_ticks;
            fresh_reports.push_back(slot_report(KIND_ACCEPTED, TXS_OK, b.seq,
                                                4'(slot), 8'd0));
          end else begin
            trk_busy[slot] = 1'b0;
            fresh_reports.push_back(slot_report(KIND_FAILED,
                (b.radio_result == RADIO_ERR) ? TXS_ERR : TXS_FATAL, b.seq,
                4'(slot), 8'd0));
          end
        end
      end
      CMD_STATUS: begin
        hit = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
          if (!hit && trk_busy[i] && trk_seq[i] == b.seq) begin
            hit         = 1'b1;
            trk_busy[i] = 1'b0;
            fresh_reports.push_back(slot_report(KIND_MATCHED,
                b.success ? TXS_OK : TXS_ERR, b.seq, 4'(i), b.tx_count));
          end
        end
        if (!hit) begin
          fresh_reports.push_back(slot_report(KIND_UNMATCHED, TXS_FATAL, b.seq,
                                              4'd0, 8'd0));
        end
      end
      CMD_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (trk_busy[i]) begin
            if (trk_count[i] <= 16'd1) begin
              trk_busy[i]  = 1'b0;
              trk_count[i] = 16'd0;
              fresh_reports.push_back(slot_report(KIND_TIMEOUT, TXS_NOACK, trk_seq[i],
                                                  4'(i), TIMEOUT_TRIES));
            end else begin
              trk_count[i] = trk_count[i] - 16'd1;
            end
          end
        end
      end
      default: ;
    endcase
    // Only the final report of a beat carries last
    foreach (fresh_reports[k]) begin
      r                = fresh_reports[k];
      r.last           = (k == fresh_reports.size() - 1);
      fresh_reports[k] = r;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (fail_count < MAX_PRINTS) begin
      $display("mismatch on result %0d: %s got %0d want %0d", reports_seen, what, got,
               want);
    end
    fail_count++;
  endtask

  task automatic check_report(out_item_t got);
    out_item_t want;
    if (due_reports.size() == 0) begin
      report_mismatch("result with nothing pending, kind", got.result_kind, -1);
    end else begin
      want = due_reports.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", got.result_kind, want.result_kind);
      if (got.tx_status !== want.tx_status)
        report_mismatch("tx_status", got.tx_status, want.tx_status);
      if (got.report_seq !== want.report_seq)
        report_mismatch("report_seq", got.report_seq, want.report_seq);
      if (got.slot_index !== want.slot_index)
        report_mismatch("slot_index", got.slot_index, want.slot_index);
      if (got.attempts !== want.attempts)
        report_mismatch("attempts", got.attempts, want.attempts);
      if (got.last !== want.last)
        report_mismatch("last", got.last, want.last);
    end
    reports_seen++;
  endtask

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Hold one beat until accepted, then score it
  task automatic offer(in_item_t b, bit typed, out_item_t want);
    int gap;
    in_valid_i <= 1'b1;
    in_item_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    advance_slots(b);
    if (typed) begin
      due_reports.push_back(want);
    end else begin
      foreach (fresh_reports[k]) due_reports.push_back(fresh_reports[k]);
    end
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until the block has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_wait_ticks(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    tb_wait_ticks = v;
    cfg_we_i    <= 1'b0;
  endtask

  function automatic void add_row(in_item_t b);
    stim_row_t row;
    row.beat  = b;
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_typed_row(in_item_t b, out_item_t want);
    stim_row_t row;
    row.beat  = b;
    row.typed = 1'b1;
    row.want  = want;
    plan.push_back(row);
  endfunction

  // Directed table, run with wait_ticks set to 1
  function automatic void load_plan();
    add_typed_row(status_of(8'h00, 1'b1, 8'h00),
                  slot_report(KIND_UNMATCHED, TXS_FATAL, 8'h00, 4'd0, 8'd0));
    add_row(tick_of(CMD_TICK));
    add_typed_row(send_of(8'hff, 1'b0, 1'b0, RADIO_OK),
                  slot_report(KIND_FAILED, TXS_FATAL, 8'hff, 4'd0, 8'd0));
    add_row(send_of(8'h10, 1'b0, 1'b1, RADIO_OK));
    add_row(send_of(8'h11, 1'b0, 1'b1, RADIO_OK));
    add_row(send_of(8'h20, 1'b1, 1'b1, RADIO_OK));
    add_row(send_of(8'h21, 1'b1, 1'b1, RADIO_OK));
    add_row(send_of(8'h22, 1'b1, 1'b1, RADIO_OK));
    add_row(send_of(8'h23, 1'b1, 1'b1, RADIO_OK));
    // management slots full
    add_typed_row(send_of(8'h24, 1'b1, 1'b1, RADIO_OK),
                  slot_report(KIND_FAILED, TXS_FATAL, 8'h24, 4'd0, 8'd0));
    add_row(status_of(8'h21, 1'b1, 8'hff));
    // radio failures leave free the slot they would take
    add_typed_row(send_of(8'h30, 1'b1, 1'b1, RADIO_ERR),
                  slot_report(KIND_FAILED, TXS_ERR, 8'h30, 4'd2, 8'd0));
    add_typed_row(send_of(8'h31, 1'b1, 1'b1, RADIO_FATAL),
                  slot_report(KIND_FAILED, TXS_FATAL, 8'h31, 4'd2, 8'd0));
    add_row(status_of(8'h10, 1'b0, 8'h00));
    add_typed_row(send_of(8'h40, 1'b0, 1'b1, RADIO_ERR),
                  slot_report(KIND_FAILED, TXS_ERR, 8'h40, 4'd0, 8'd0));
    add_typed_row(send_of(8'h41, 1'b0, 1'b1, RADIO_BAD),
                  slot_report(KIND_FAILED, TXS_FATAL, 8'h41, 4'd0, 8'd0));
    // same sequence in data and management slots: data slot matches first
    add_row(send_of(8'h22, 1'b0, 1'b1, RADIO_OK));
    add_row(status_of(8'h22, 1'b1, 8'h03));
    add_row(status_of(8'h22, 1'b0, 8'h80));
    // two management slots with one sequence: lowest matches
    add_row(send_of(8'h23, 1'b1, 1'b1, RADIO_OK));
    add_row(status_of(8'h23, 1'b1, 8'h01));
    // fill every slot, then one tick expires them all
    add_row(send_of(8'h50, 1'b0, 1'b1, RADIO_OK));
    add_row(send_of(8'h51, 1'b1, 1'b1, RADIO_OK));
    add_row(send_of(8'h52, 1'b1, 1'b1, RADIO_OK));
    add_row(tick_of(CMD_TICK));
    add_row(tick_of(CMD_UNUSED));
  endfunction

  function automatic logic [1:0] pick_radio();
    if ($urandom_range(0, 99) < 85) return RADIO_OK;
    return 2'($urandom_range(1, 3));
  endfunction

  // Mostly well-formed traffic: sends, reports for busy slots, ticks
  function automatic in_item_t pick_beat();
    int r;
    int start;
    int s;
    int k;
    in_item_t b;
    r = $urandom_range(0, 99);
    if (r < 34) begin
      b = send_of(8'($urandom), $urandom_range(0, 99) < 65, $urandom_range(0, 99) < 95,
                  pick_radio());
    end else if (r < 62) begin
      start = $urandom_range(0, SLOTS - 1);
      s = -1;
      for (k = 0; k < SLOTS; k++) begin
        if (s < 0 && trk_busy[(start + k) % SLOTS]) s = (start + k) % SLOTS;
      end
      if (s >= 0 && $urandom_range(0, 9) != 0)
        b = status_of(trk_seq[s], 1'($urandom), 8'($urandom));
      else
        b = status_of(8'($urandom), 1'($urandom), 8'($urandom));
    end else if (r < 88) begin
      b = tick_of(CMD_TICK);
    end else begin
      b = in_item_t'(ITEM_W'($urandom));
    end
    return b;
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned n;
    in_item_t    b;
    n = 0;
    while (n < count) begin
      calm = ((n / 16) % 4) == 3;
      b = pick_beat();
      offer(b, 1'b0, '0);
      if (b.command != CMD_UNUSED) n++;
    end
    calm = 1'b0;
  endtask

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    int          gap;
    int unsigned beats_taken;
    bit          held;
    beats_taken = 0;
    held        = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_report(out_item_o);
        beats_taken++;
      end
      if (out_ready_i) begin
        if (!held && beats_taken >= HOLD_AFTER) begin
          held = 1'b1;
          gap  = HOLD_CYCLES;
        end else begin
          gap = idle_len();
        end
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Stimulus and final verdict
  initial begin
    fail_count    = 0;
    reports_seen  = 0;
    calm          = 1'b0;
    tb_wait_ticks = WAIT_TICKS_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      trk_busy[i]  = 1'b0;
      trk_seq[i]   = '0;
      trk_count[i] = '0;
    end
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_wait_ticks(16'd1);
    load_plan();
    foreach (plan[i]) offer(plan[i].beat, plan[i].typed, plan[i].want);
    drain();

    foreach (PHASE_WAIT[p]) begin
      set_wait_ticks(PHASE_WAIT[p]);
      run_random(PHASE_ITEMS);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
